FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the segment distance block.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("assertion failed");
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rstn, cond)
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

FILE: hw/rtl/ssd_pkg.sv
// Package of the segment distance block: widths, the job word that
// passes from the front end to the back end, and the geometry record.
// No dependencies.
package ssd_pkg;

    localparam int COORD_W     = 24;
    localparam int PQ_W        = 25;
    localparam int PROD_W      = COORD_W + PQ_W;
    localparam int DOT_W       = 51;
    localparam int WIDE_W      = 103;
    localparam int DIV_W       = 103;
    localparam int CFG_W       = 32;
    localparam logic [CFG_W-1:0] THR_RESET = 32'd4295;
    localparam int IN_TDATA_W  = 8 * COORD_W;
    localparam int DIST_W      = 63;
    localparam int PARAM_W     = 18;
    localparam int OUT_TDATA_W = 104;
    localparam int OUT_PAD     = OUT_TDATA_W - DIST_W - 2 * PARAM_W;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef struct packed {
        logic signed [COORD_W-1:0] hax;
        logic signed [COORD_W-1:0] hay;
        logic signed [COORD_W-1:0] hbx;
        logic signed [COORD_W-1:0] hby;
        logic signed [PQ_W-1:0]    pqx;
        logic signed [PQ_W-1:0]    pqy;
    } ssd_geom_t;

    typedef struct packed {
        logic signed [DOT_W-1:0] a;
        logic signed [DOT_W-1:0] b;
        logic signed [DOT_W-1:0] c;
        logic signed [DOT_W-1:0] d;
        logic signed [DOT_W-1:0] e;
    } ssd_dots_t;

    typedef struct packed {
        ssd_geom_t        geom;
        logic             par;
        logic [DIV_W-1:0] s_mag;
        logic [DIV_W-1:0] s_den;
        logic             s_neg;
        logic [DIV_W-1:0] t_mag;
        logic [DIV_W-1:0] t_den;
        logic             t_neg;
    } ssd_job_t;

endpackage

FILE: hw/rtl/segment_segment_distance_2d_top.sv
// Top level of the 2D segment-to-segment closest distance engine.
// Depends on ssd_pkg, ssd_front, ssd_queue and ssd_back.
//
//  channel  | ports                            | word
//  ---------+----------------------------------+-------------------------------
//  input    | s_tvalid s_tready s_tdata[191:0] | two segments, centre + half
//  result   | m_tvalid m_tready m_tdata[103:0] | squared distance, s, t
//           | m_tuser                          | near-parallel flag
//  config   | cfg_we cfg_wdata[31:0]           | parallel threshold
//
// One word is taken per cycle while s_tready is high, and one result word
// leaves per cycle while m_tready is high; a word passes through the
// nine-stage front end, the queue, and the dividers that produce one
// quotient bit per stage. Reset (aresetn low at a rising edge) empties every
// stage and the queue and loads the threshold with 4295. A stall on the result
// side freezes the back end only; the front end keeps taking words until the
// four-entry queue between them fills, and s_tready then drops.
module segment_segment_distance_2d_top import ssd_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // Threshold register: write enable and data, no read-back.
    input  logic                   cfg_we,
    input  logic [CFG_W-1:0]       cfg_wdata,
    // center_a_x, center_a_y, half_a_x, half_a_y, center_b_x, center_b_y,
    // half_b_x, half_b_y; 24 bits each, lowest field first.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // distance_squared [62:0], param_a [80:63], param_b [98:81], zeros above.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // near_parallel
    output logic                   m_tuser
);
    ssd_job_t front_job, queue_job;
    logic     front_valid, queue_full, queue_valid, queue_pop;

    // The front end classifies each pair into two division jobs.
    ssd_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_data    (s_tdata),
        .job_valid  (front_valid),
        .job        (front_job),
        .queue_full (queue_full)
    );

    // The queue lets the two halves stall independently.
    ssd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (front_valid),
        .push_data  (front_job),
        .full       (queue_full),
        .pop        (queue_pop),
        .pop_valid  (queue_valid),
        .pop_data   (queue_job)
    );

    // The back end divides, forms the closest points and the distance.
    ssd_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (queue_valid),
        .job       (queue_job),
        .job_pop   (queue_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );
endmodule

FILE: hw/rtl/ssd_mul.sv
// Two-stage signed multiplier built from four half-width partial products.
// No dependencies.
module ssd_mul #(
    parameter int AW = 51,
    parameter int BW = 51
) (
    input  logic                    aclk,
    input  logic                    en,
    input  logic signed [AW-1:0]    a,
    input  logic signed [BW-1:0]    b,
    output logic signed [AW+BW-1:0] p
);
    localparam int LA = AW / 2;
    localparam int LB = BW / 2;
    localparam int HA = AW - LA;
    localparam int HB = BW - LB;
    localparam int PW = AW + BW;

    logic signed [HA-1:0] a_hi;
    logic signed [LA:0]   a_lo;
    logic signed [HB-1:0] b_hi;
    logic signed [LB:0]   b_lo;

    logic signed [HA+HB-1:0]   hh_reg;
    logic signed [HA+LB:0]     hl_reg;
    logic signed [LA+HB:0]     lh_reg;
    logic signed [LA+LB+1:0]   ll_reg;
    logic signed [PW-1:0]      p_reg;

    assign a_hi = a[AW-1:LA];
    assign a_lo = $signed({1'b0, a[LA-1:0]});
    assign b_hi = b[BW-1:LB];
    assign b_lo = $signed({1'b0, b[LB-1:0]});

    always_ff @(posedge aclk) begin
        if (en) begin
            hh_reg <= a_hi * b_hi;
            hl_reg <= a_hi * b_lo;
            lh_reg <= a_lo * b_hi;
            ll_reg <= a_lo * b_lo;
            p_reg  <= (PW'(hh_reg) <<< (LA + LB)) + (PW'(hl_reg) <<< LA)
                    + (PW'(lh_reg) <<< LB) + PW'(ll_reg);
        end
    end

    assign p = p_reg;
endmodule

FILE: hw/rtl/ssd_div.sv
// Pipelined restoring divider: one quotient bit per stage, result clamped
// to the range -1..+1 in FRAC_BITS fraction bits. Depends on ssd_pkg.
module ssd_div import ssd_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                      aclk,
    input  logic                      en,
    input  logic [DIV_W-1:0]          mag,
    input  logic [DIV_W-1:0]          den,
    input  logic                      neg,
    output logic signed [FRAC_BITS+1:0] quo
);
    localparam int RW = DIV_W + 1;
    localparam int QW = FRAC_BITS + 2;
    localparam logic [QW-1:0] ONE = QW'(1) << FRAC_BITS;

    logic [RW-1:0]        r_reg    [0:FRAC_BITS];
    logic [DIV_W-1:0]     d_reg    [0:FRAC_BITS];
    logic [FRAC_BITS-1:0] q_reg    [0:FRAC_BITS];
    logic                 n_reg    [0:FRAC_BITS];
    logic                 sat_reg  [0:FRAC_BITS];
    logic                 zero_reg [0:FRAC_BITS];
    logic [RW-1:0]        r_next   [1:FRAC_BITS];
    logic [FRAC_BITS-1:0] q_next   [1:FRAC_BITS];
    logic [RW-1:0]        shifted  [1:FRAC_BITS];
    logic [QW-1:0]        mag_q;
    logic signed [QW-1:0] quo_reg;

    // Each stage doubles the remainder and takes off the divisor when it fits.
    always_comb begin
        for (int i = 1; i <= FRAC_BITS; i++) begin
            shifted[i] = {r_reg[i-1][RW-2:0], 1'b0};
            if (shifted[i] >= {1'b0, d_reg[i-1]}) begin
                r_next[i] = shifted[i] - {1'b0, d_reg[i-1]};
                q_next[i] = {q_reg[i-1][FRAC_BITS-2:0], 1'b1};
            end else begin
                r_next[i] = shifted[i];
                q_next[i] = {q_reg[i-1][FRAC_BITS-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        if (zero_reg[FRAC_BITS]) begin
            mag_q = '0;
        end else if (sat_reg[FRAC_BITS]) begin
            mag_q = ONE;
        end else begin
            mag_q = QW'(q_reg[FRAC_BITS]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg[0]    <= RW'(mag);
            d_reg[0]    <= den;
            q_reg[0]    <= '0;
            n_reg[0]    <= neg;
            sat_reg[0]  <= (mag >= den);
            zero_reg[0] <= (den == '0);
            for (int i = 1; i <= FRAC_BITS; i++) begin
                r_reg[i]    <= r_next[i];
                d_reg[i]    <= d_reg[i-1];
                q_reg[i]    <= q_next[i];
                n_reg[i]    <= n_reg[i-1];
                sat_reg[i]  <= sat_reg[i-1];
                zero_reg[i] <= zero_reg[i-1];
            end
            quo_reg <= n_reg[FRAC_BITS] ? -$signed(mag_q) : $signed(mag_q);
        end
    end

    assign quo = quo_reg;
endmodule

FILE: hw/rtl/ssd_front.sv
// Front end: accepts a segment pair, forms the dot products and the
// determinant, and classifies the case into two division jobs. Depends on
// ssd_pkg and ssd_mul.
module ssd_front import ssd_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_W-1:0]      cfg_wdata,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [IN_TDATA_W-1:0] in_data,
    output logic                  job_valid,
    output ssd_job_t              job,
    input  logic                  queue_full
);
    localparam int SH = 4 * FRAC_BITS - 32;
    localparam int SW = DOT_W + 1;

    function automatic logic [DIV_W-1:0] mag_w(input logic signed [WIDE_W-1:0] v);
        mag_w = v[WIDE_W-1] ? DIV_W'($unsigned(-v)) : DIV_W'($unsigned(v));
    endfunction

    function automatic logic [DIV_W-1:0] mag_s(input logic signed [SW-1:0] v);
        mag_s = v[SW-1] ? DIV_W'($unsigned(-v)) : DIV_W'($unsigned(v));
    endfunction

    logic                  fe;
    logic [9:1]            v_reg;
    logic [CFG_W-1:0]      thr_reg;
    ssd_geom_t             geom_reg [1:9];
    ssd_geom_t             geom_next;
    logic signed [COORD_W-1:0] cax, cay, cbx, cby;

    logic signed [PROD_W-1:0] pr_reg [10];
    ssd_dots_t             dots_reg [3:5];

    logic signed [2*DOT_W-1:0] ac, bb, be_p, cd, ae, bd;

    // stage 6
    logic signed [WIDE_W-1:0] det6_reg, ns6_reg, nt6_reg;
    logic signed [SW-1:0]     epb6_reg, emb6_reg, bmd6_reg, nbmd6_reg;
    logic                     dneg6_reg;
    logic [DIV_W-1:0]         a6_reg, c6_reg;
    // stage 7
    logic [WIDE_W-1:0]        thr_sh;
    logic                     par7_reg, dneg7_reg, nsneg7_reg, ntneg7_reg;
    logic [DIV_W-1:0]         det7_reg, nsmag7_reg, ntmag7_reg, a7_reg, c7_reg;
    logic [DIV_W-1:0]         epb7_reg, emb7_reg, bmd7_reg, nbmd7_reg;
    logic                     epbn7_reg, embn7_reg, bmdn7_reg, nbmdn7_reg;
    // stage 8
    logic                     fs, t_clamp, t_minus;
    logic                     par8_reg, dneg8_reg, nsneg8_reg, tneg8_reg;
    logic                     bmdn8_reg, nbmdn8_reg;
    logic [DIV_W-1:0]         det8_reg, nsmag8_reg, a8_reg, tmag8_reg, tden8_reg;
    logic [DIV_W-1:0]         bmd8_reg, nbmd8_reg;
    // stage 9
    logic                     ft;
    ssd_job_t                 job_next, job_reg;

    assign fe       = !v_reg[9] || !queue_full;
    assign in_ready = fe;

    assign cax = in_data[0*COORD_W +: COORD_W];
    assign cay = in_data[1*COORD_W +: COORD_W];
    assign cbx = in_data[4*COORD_W +: COORD_W];
    assign cby = in_data[5*COORD_W +: COORD_W];

    always_comb begin
        geom_next.hax = in_data[2*COORD_W +: COORD_W];
        geom_next.hay = in_data[3*COORD_W +: COORD_W];
        geom_next.hbx = in_data[6*COORD_W +: COORD_W];
        geom_next.hby = in_data[7*COORD_W +: COORD_W];
        geom_next.pqx = PQ_W'(cax) - PQ_W'(cbx);
        geom_next.pqy = PQ_W'(cay) - PQ_W'(cby);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg   <= '0;
            thr_reg <= THR_RESET;
        end else begin
            if (fe) begin
                v_reg <= {v_reg[8:1], in_valid};
            end
            if (cfg_we) begin
                thr_reg <= cfg_wdata;
            end
        end
    end

    ssd_mul #(.AW(DOT_W), .BW(DOT_W)) u_mul_ac (
        .aclk(aclk), .en(fe), .a(dots_reg[3].a), .b(dots_reg[3].c), .p(ac));
    ssd_mul #(.AW(DOT_W), .BW(DOT_W)) u_mul_bb (
        .aclk(aclk), .en(fe), .a(dots_reg[3].b), .b(dots_reg[3].b), .p(bb));
    ssd_mul #(.AW(DOT_W), .BW(DOT_W)) u_mul_be (
        .aclk(aclk), .en(fe), .a(dots_reg[3].b), .b(dots_reg[3].e), .p(be_p));
    ssd_mul #(.AW(DOT_W), .BW(DOT_W)) u_mul_cd (
        .aclk(aclk), .en(fe), .a(dots_reg[3].c), .b(dots_reg[3].d), .p(cd));
    ssd_mul #(.AW(DOT_W), .BW(DOT_W)) u_mul_ae (
        .aclk(aclk), .en(fe), .a(dots_reg[3].a), .b(dots_reg[3].e), .p(ae));
    ssd_mul #(.AW(DOT_W), .BW(DOT_W)) u_mul_bd (
        .aclk(aclk), .en(fe), .a(dots_reg[3].b), .b(dots_reg[3].d), .p(bd));

    assign thr_sh = WIDE_W'(thr_reg) << SH;

    // Case selection: t comes from the clamped s when the segments are
    // near-parallel or s overflows; s, from the clamped t when t overflows.
    always_comb begin
        fs      = !par7_reg && (det7_reg != '0) && (nsmag7_reg > det7_reg);
        t_clamp = par7_reg || fs;
        t_minus = par7_reg ? dneg7_reg : nsneg7_reg;
        ft      = (tden8_reg != '0) && (tmag8_reg > tden8_reg);
    end

    always_comb begin
        job_next.geom  = geom_reg[8];
        job_next.par   = par8_reg;
        job_next.t_mag = tmag8_reg;
        job_next.t_den = tden8_reg;
        job_next.t_neg = tneg8_reg;
        if (ft) begin
            job_next.s_mag = tneg8_reg ? nbmd8_reg : bmd8_reg;
            job_next.s_neg = tneg8_reg ? nbmdn8_reg : bmdn8_reg;
            job_next.s_den = a8_reg;
        end else if (par8_reg) begin
            job_next.s_mag = DIV_W'(1);
            job_next.s_den = DIV_W'(1);
            job_next.s_neg = dneg8_reg;
        end else begin
            job_next.s_mag = nsmag8_reg;
            job_next.s_den = det8_reg;
            job_next.s_neg = nsneg8_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fe) begin
            geom_reg[1] <= geom_next;
            for (int k = 2; k <= 9; k++) begin
                geom_reg[k] <= geom_reg[k-1];
            end
            // stage 2: the ten coordinate products
            pr_reg[0] <= geom_reg[1].hax * geom_reg[1].hax;
            pr_reg[1] <= geom_reg[1].hay * geom_reg[1].hay;
            pr_reg[2] <= geom_reg[1].hax * geom_reg[1].hbx;
            pr_reg[3] <= geom_reg[1].hay * geom_reg[1].hby;
            pr_reg[4] <= geom_reg[1].hbx * geom_reg[1].hbx;
            pr_reg[5] <= geom_reg[1].hby * geom_reg[1].hby;
            pr_reg[6] <= geom_reg[1].hax * geom_reg[1].pqx;
            pr_reg[7] <= geom_reg[1].hay * geom_reg[1].pqy;
            pr_reg[8] <= geom_reg[1].hbx * geom_reg[1].pqx;
            pr_reg[9] <= geom_reg[1].hby * geom_reg[1].pqy;
            // stage 3: dot products
            dots_reg[3].a <= DOT_W'(pr_reg[0]) + DOT_W'(pr_reg[1]);
            dots_reg[3].b <= DOT_W'(pr_reg[2]) + DOT_W'(pr_reg[3]);
            dots_reg[3].c <= DOT_W'(pr_reg[4]) + DOT_W'(pr_reg[5]);
            dots_reg[3].d <= DOT_W'(pr_reg[6]) + DOT_W'(pr_reg[7]);
            dots_reg[3].e <= DOT_W'(pr_reg[8]) + DOT_W'(pr_reg[9]);
            dots_reg[4]   <= dots_reg[3];
            dots_reg[5]   <= dots_reg[4];
            // stage 6: determinant and numerators
            det6_reg  <= WIDE_W'(ac) - WIDE_W'(bb);
            ns6_reg   <= WIDE_W'(be_p) - WIDE_W'(cd);
            nt6_reg   <= WIDE_W'(ae) - WIDE_W'(bd);
            epb6_reg  <= SW'(dots_reg[5].e) + SW'(dots_reg[5].b);
            emb6_reg  <= SW'(dots_reg[5].e) - SW'(dots_reg[5].b);
            bmd6_reg  <= SW'(dots_reg[5].b) - SW'(dots_reg[5].d);
            nbmd6_reg <= -SW'(dots_reg[5].b) - SW'(dots_reg[5].d);
            dneg6_reg <= dots_reg[5].d[DOT_W-1];
            a6_reg    <= DIV_W'($unsigned(dots_reg[5].a));
            c6_reg    <= DIV_W'($unsigned(dots_reg[5].c));
            // stage 7: threshold test and magnitudes
            par7_reg   <= $unsigned(det6_reg) < thr_sh;
            det7_reg   <= DIV_W'($unsigned(det6_reg));
            nsmag7_reg <= mag_w(ns6_reg);
            nsneg7_reg <= ns6_reg[WIDE_W-1];
            ntmag7_reg <= mag_w(nt6_reg);
            ntneg7_reg <= nt6_reg[WIDE_W-1];
            epb7_reg   <= mag_s(epb6_reg);
            epbn7_reg  <= epb6_reg[SW-1];
            emb7_reg   <= mag_s(emb6_reg);
            embn7_reg  <= emb6_reg[SW-1];
            bmd7_reg   <= mag_s(bmd6_reg);
            bmdn7_reg  <= bmd6_reg[SW-1];
            nbmd7_reg  <= mag_s(nbmd6_reg);
            nbmdn7_reg <= nbmd6_reg[SW-1];
            dneg7_reg  <= dneg6_reg;
            a7_reg     <= a6_reg;
            c7_reg     <= c6_reg;
            // stage 8: choose the job for the second parameter
            par8_reg   <= par7_reg;
            dneg8_reg  <= dneg7_reg;
            nsneg8_reg <= nsneg7_reg;
            nsmag8_reg <= nsmag7_reg;
            det8_reg   <= det7_reg;
            a8_reg     <= a7_reg;
            bmd8_reg   <= bmd7_reg;
            bmdn8_reg  <= bmdn7_reg;
            nbmd8_reg  <= nbmd7_reg;
            nbmdn8_reg <= nbmdn7_reg;
            if (t_clamp) begin
                tmag8_reg <= t_minus ? emb7_reg : epb7_reg;
                tneg8_reg <= t_minus ? embn7_reg : epbn7_reg;
                tden8_reg <= c7_reg;
            end else begin
                tmag8_reg <= ntmag7_reg;
                tneg8_reg <= ntneg7_reg;
                tden8_reg <= det7_reg;
            end
            // stage 9: job word
            job_reg <= job_next;
        end
    end

    assign job_valid = v_reg[9];
    assign job       = job_reg;
endmodule

FILE: hw/rtl/ssd_queue.sv
// Short job queue between the front end and the back end.
// Depends on ssd_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ssd_queue import ssd_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push_valid,
    input  ssd_job_t push_data,
    output logic     full,
    input  logic     pop,
    output logic     pop_valid,
    output ssd_job_t pop_data
);
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    ssd_job_t          mem_reg [QUEUE_DEPTH];
    logic              push;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign push      = push_valid && !full;
    assign pop_valid = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + QPTR_W'(push);
            rd_ptr_reg <= rd_ptr_reg + QPTR_W'(pop);
            count_reg  <= count_reg + QCNT_W'(push) - QCNT_W'(pop);
        end
    end

    `ASSERT_ALWAYS(a_count_bound, aclk, aresetn, count_reg <= QCNT_W'(QUEUE_DEPTH))
    `ASSERT_IMPLIES(a_pop_nonempty, aclk, aresetn, pop, count_reg != '0)
    `ASSERT_NEXT(a_count_up, aclk, aresetn, push && !pop, count_reg == $past(count_reg) + 1'b1)
endmodule

FILE: hw/rtl/ssd_back.sv
// Back end: runs the two divisions, forms the closest points and the
// squared distance, and holds the result word. Depends on ssd_pkg,
// ssd_div, ssd_mul and assert_macros.svh.
`include "assert_macros.svh"
module ssd_back import ssd_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   job_valid,
    input  ssd_job_t               job,
    output logic                   job_pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tuser
);
    localparam int SC_W    = FRAC_BITS + 2;
    localparam int DIV_LAT = FRAC_BITS + 2;
    localparam int NST     = DIV_LAT + 4;
    localparam int DXW     = FRAC_BITS + 28;
    localparam int SUMW    = 2 * DXW + 1;
    localparam int SH      = 4 * FRAC_BITS - 32;
    localparam int PXW     = SC_W + PARAM_W;
    localparam int PRW     = SC_W + COORD_W;
    localparam logic signed [SC_W-1:0] ONE = SC_W'(1) << FRAC_BITS;

    logic                   be;
    logic [NST-1:0]         v_reg;
    logic                   m_valid_reg;
    ssd_geom_t              geom_reg [0:DIV_LAT-1];
    logic                   par_reg  [0:DIV_LAT-1];
    logic signed [SC_W-1:0] sc, tc;
    logic signed [SC_W-1:0] sc_reg [1:4];
    logic signed [SC_W-1:0] tc_reg [1:4];
    logic                   pb_reg [1:4];
    logic signed [PRW-1:0]  sx_reg, sy_reg, tx_reg, ty_reg;
    logic signed [DXW-1:0]  pqx_reg, pqy_reg, dx_reg, dy_reg;
    logic signed [2*DXW-1:0] dx2, dy2;
    logic [SUMW-1:0]        sum_next, sum_sh;
    logic [DIST_W-1:0]      dist_next;
    logic signed [PXW-1:0]  pa_ext, pb_ext;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    logic                   m_tuser_reg;

    // The whole back end moves together; the result register is its end.
    assign be      = !m_valid_reg || m_tready;
    assign job_pop = be && job_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else if (be) begin
            v_reg       <= {v_reg[NST-2:0], job_valid};
            m_valid_reg <= v_reg[NST-1];
        end
    end

    ssd_div #(.FRAC_BITS(FRAC_BITS)) u_div_s (
        .aclk(aclk), .en(be), .mag(job.s_mag), .den(job.s_den), .neg(job.s_neg), .quo(sc));
    ssd_div #(.FRAC_BITS(FRAC_BITS)) u_div_t (
        .aclk(aclk), .en(be), .mag(job.t_mag), .den(job.t_den), .neg(job.t_neg), .quo(tc));

    ssd_mul #(.AW(DXW), .BW(DXW)) u_sq_x (
        .aclk(aclk), .en(be), .a(dx_reg), .b(dx_reg), .p(dx2));
    ssd_mul #(.AW(DXW), .BW(DXW)) u_sq_y (
        .aclk(aclk), .en(be), .a(dy_reg), .b(dy_reg), .p(dy2));

    always_comb begin
        sum_next = SUMW'($unsigned(dx2)) + SUMW'($unsigned(dy2));
        sum_sh   = sum_next >> SH;
        if (|sum_sh[SUMW-1:DIST_W]) begin
            dist_next = '1;
        end else begin
            dist_next = sum_sh[DIST_W-1:0];
        end
        pa_ext = PXW'(sc_reg[4]);
        pb_ext = PXW'(tc_reg[4]);
    end

    always_ff @(posedge aclk) begin
        if (be) begin
            geom_reg[0] <= job.geom;
            par_reg[0]  <= job.par;
            for (int k = 1; k < DIV_LAT; k++) begin
                geom_reg[k] <= geom_reg[k-1];
                par_reg[k]  <= par_reg[k-1];
            end
            // first stage after the dividers: scaled offsets
            sx_reg    <= sc * geom_reg[DIV_LAT-1].hax;
            sy_reg    <= sc * geom_reg[DIV_LAT-1].hay;
            tx_reg    <= tc * geom_reg[DIV_LAT-1].hbx;
            ty_reg    <= tc * geom_reg[DIV_LAT-1].hby;
            pqx_reg   <= DXW'(geom_reg[DIV_LAT-1].pqx) <<< FRAC_BITS;
            pqy_reg   <= DXW'(geom_reg[DIV_LAT-1].pqy) <<< FRAC_BITS;
            sc_reg[1] <= sc;
            tc_reg[1] <= tc;
            pb_reg[1] <= par_reg[DIV_LAT-1];
            // difference vector between the closest points
            dx_reg    <= pqx_reg + DXW'(sx_reg) - DXW'(tx_reg);
            dy_reg    <= pqy_reg + DXW'(sy_reg) - DXW'(ty_reg);
            for (int k = 2; k <= 4; k++) begin
                sc_reg[k] <= sc_reg[k-1];
                tc_reg[k] <= tc_reg[k-1];
                pb_reg[k] <= pb_reg[k-1];
            end
            m_tdata_reg <= {{OUT_PAD{1'b0}}, pb_ext[PARAM_W-1:0], pa_ext[PARAM_W-1:0],
                            dist_next};
            m_tuser_reg <= pb_reg[4];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `ASSERT_IMPLIES(a_sc_range, aclk, aresetn, v_reg[NST-1],
        (sc_reg[4] <= ONE) && (sc_reg[4] >= -ONE))
    `ASSERT_IMPLIES(a_tc_range, aclk, aresetn, v_reg[NST-1],
        (tc_reg[4] <= ONE) && (tc_reg[4] >= -ONE))
    `ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_valid_reg && !m_tready,
        $stable(sc_reg[4]) && $stable(v_reg))
endmodule
